/* design/repeating_decimal_period_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for repeating_decimal_period
// Shared helpers for concurrent checks, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REPEATING_DECIMAL_PERIOD_ASSERT_SVH
`define REPEATING_DECIMAL_PERIOD_ASSERT_SVH

// Same-cycle implication.
`define RDP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rdp assertion failed");

// Next-cycle implication.
`define RDP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rdp assertion failed");

`endif

/* design/rdp_pkg.sv */
// ----------------------------------------------------------------------------
// rdp_pkg
// Widths, limits and the command and status bundles of the period finder.
// ----------------------------------------------------------------------------
package rdp_pkg;

  localparam int MaxDen = 4096;
  localparam int NumW   = 32;
  localparam int DenW   = 13;
  localparam int RemW   = $clog2(MaxDen);
  localparam int CntW   = 13;
  localparam int MemW   = CntW + 1;

  typedef struct packed {
    logic load;
    logic clear;
    logic init;
    logic step;
    logic record;
    logic hit_fin;
    logic zero_fin;
    logic out_load;
  } rdp_cmd_t;

  typedef struct packed {
    logic bad_den;
    logic clear_fin;
    logic div_done;
    logic rem_zero;
    logic hit;
    logic out_free;
  } rdp_sts_t;

endpackage

/* design/rdp_div.sv */
// ----------------------------------------------------------------------------
// rdp_div
// Restoring divider, one quotient bit per cycle, for the integer part.
// ----------------------------------------------------------------------------
module rdp_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rdp_pkg::NumW-1:0] num_i,
  input  logic [rdp_pkg::DenW-1:0] den_i,
  output logic [rdp_pkg::NumW-1:0] quot_o,
  output logic [rdp_pkg::RemW-1:0] rem_o,
  output logic                     done_o
);
  import rdp_pkg::*;

  localparam int CntBits = $clog2(NumW);

  logic [NumW-1:0]    quot_q;
  logic [RemW-1:0]    rem_q;
  logic [DenW-1:0]    den_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic [DenW-1:0]    trial;
  logic [DenW-1:0]    diff;
  logic               ge;

  assign trial = {rem_q, quot_q[NumW-1]};
  assign ge    = trial >= den_q;
  assign diff  = trial - den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntBits'(NumW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NumW-2:0], ge};
      rem_q  <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = !busy_q;

endmodule

/* design/rdp_datapath.sv */
// ----------------------------------------------------------------------------
// rdp_datapath
// Remainder table, digit step logic, result registers and output stage.
// ----------------------------------------------------------------------------
module rdp_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rdp_pkg::rdp_cmd_t        cmd_i,
  output rdp_pkg::rdp_sts_t        sts_o,
  input  logic [rdp_pkg::NumW-1:0] numerator_i,
  input  logic [rdp_pkg::DenW-1:0] denominator_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [rdp_pkg::NumW-1:0] integer_part_o,
  output logic [rdp_pkg::CntW-1:0] prefix_length_o,
  output logic [rdp_pkg::CntW-1:0] cycle_length_o,
  output logic                     status_o
);
  import rdp_pkg::*;

  function automatic logic [RemW-1:0] dbl_mod(input logic [RemW-1:0] x,
                                              input logic [DenW-1:0] d);
    logic [DenW-1:0] y;
    y = {x, 1'b0};
    if (y >= d) y = y - d;
    return y[RemW-1:0];
  endfunction

  logic [MemW-1:0] table_mem [MaxDen];

  logic [DenW-1:0] den_q;
  logic            bad_q;
  logic [CntW-1:0] clr_q;
  logic [RemW-1:0] cur_q;
  logic [CntW-1:0] digit_q;
  logic [MemW-1:0] rd_q;
  logic [CntW-1:0] prefix_q;
  logic [CntW-1:0] cycle_q;
  logic            out_valid_q;

  logic [NumW-1:0] quot;
  logic [RemW-1:0] div_rem;
  logic            div_done;
  logic [RemW-1:0] rem2;
  logic [RemW-1:0] rem4;
  logic [RemW-1:0] rem8;
  logic [DenW-1:0] sum10;
  logic [RemW-1:0] nxt_rem;
  logic            wr_en;
  logic [RemW-1:0] wr_addr;
  logic [MemW-1:0] wr_data;
  logic [CntW-1:0] digit_inc;

  rdp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.load),
    .num_i  (numerator_i),
    .den_i  (denominator_i),
    .quot_o (quot),
    .rem_o  (div_rem),
    .done_o (div_done)
  );

  always_comb begin
    rem2    = dbl_mod(cur_q, den_q);
    rem4    = dbl_mod(rem2, den_q);
    rem8    = dbl_mod(rem4, den_q);
    sum10   = {1'b0, rem8} + {1'b0, rem2};
    if (sum10 >= den_q) sum10 = sum10 - den_q;
    nxt_rem = sum10[RemW-1:0];
  end

  assign digit_inc = digit_q + 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = '0;
    priority if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q[RemW-1:0];
      wr_data = '0;
    end else if (cmd_i.init) begin
      wr_en   = 1'b1;
      wr_addr = div_rem;
      wr_data = {1'b1, {CntW{1'b0}}};
    end else if (cmd_i.record) begin
      wr_en   = 1'b1;
      wr_addr = cur_q;
      wr_data = {1'b1, digit_inc};
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.step) begin
      rd_q <= table_mem[nxt_rem];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      den_q <= denominator_i;
      bad_q <= sts_o.bad_den;
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
    if (cmd_i.init) begin
      cur_q   <= div_rem;
      digit_q <= '0;
    end else if (cmd_i.step) begin
      cur_q <= nxt_rem;
    end else if (cmd_i.record) begin
      digit_q <= digit_inc;
    end
    if (cmd_i.zero_fin) begin
      prefix_q <= digit_q;
      cycle_q  <= CntW'(1);
    end else if (cmd_i.hit_fin) begin
      prefix_q <= rd_q[CntW-1:0];
      cycle_q  <= digit_q - rd_q[CntW-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      integer_part_o  <= bad_q ? '0 : quot;
      prefix_length_o <= bad_q ? '0 : prefix_q;
      cycle_length_o  <= bad_q ? '0 : cycle_q;
      status_o        <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.bad_den   = (denominator_i == '0) || (denominator_i > DenW'(MaxDen));
  assign sts_o.clear_fin = clr_q == den_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.rem_zero  = cur_q == '0;
  assign sts_o.hit       = rd_q[MemW-1];
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

/* design/rdp_ctrl.sv */
// ----------------------------------------------------------------------------
// rdp_ctrl
// Sequencer for one item: table clear, digit steps, result hand-off.
// ----------------------------------------------------------------------------
`include "repeating_decimal_period_assert.svh"

module rdp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rdp_pkg::rdp_sts_t sts_i,
  output rdp_pkg::rdp_cmd_t cmd_o
);
  import rdp_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StClear  = 6'b000010,
    StInit   = 6'b000100,
    StStep   = 6'b001000,
    StLook   = 6'b010000,
    StFinish = 6'b100000
  } rdp_state_e;

  rdp_state_e state_q;
  rdp_state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.bad_den ? StFinish : StClear;
        end
      end
      StClear: begin
        cmd_o.clear = !sts_i.clear_fin;
        if (sts_i.clear_fin && sts_i.div_done) begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = StStep;
      end
      StStep: begin
        if (sts_i.rem_zero) begin
          cmd_o.zero_fin = 1'b1;
          state_d        = StFinish;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = StLook;
        end
      end
      StLook: begin
        if (sts_i.hit) begin
          cmd_o.hit_fin = 1'b1;
          state_d       = StFinish;
        end else begin
          cmd_o.record = 1'b1;
          state_d      = StStep;
        end
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != StIdle;

  `RDP_ASSERT_NXT(a_bad_den_skips_work, state_q == StIdle && in_valid_i && sts_i.bad_den, state_q == StFinish)
  `RDP_ASSERT_IMP(a_look_after_step, state_q == StLook, $past(state_q) == StStep)
  `RDP_ASSERT_IMP(a_init_after_divide, state_q == StInit, $past(sts_i.div_done) && $past(sts_i.clear_fin))
  `RDP_ASSERT_NXT(a_clear_advances, state_q == StClear && !sts_i.clear_fin, state_q == StClear)

endmodule

/* design/repeating_decimal_period.sv */
// ----------------------------------------------------------------------------
// repeating_decimal_period
// Finds the integer quotient, the non-repeating prefix length and the cycle
// length of the decimal expansion of numerator / denominator.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next item is taken while the previous
// result still waits in the output register. For a denominator d in the valid
// range an item passes through an accept step, a clear phase in which the
// remainder table is cleared over its first d entries while the 32-step
// divider runs, a setup step, a table read and then a table write per fraction
// digit, and a hand-off step. The single-port remainder table sets the pace of
// the digit steps. A denominator of zero or above 4096 gives status 1 without
// the table clear or the digit steps.
module repeating_decimal_period (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [rdp_pkg::NumW-1:0] numerator_i,
  input  logic [rdp_pkg::DenW-1:0] denominator_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [rdp_pkg::NumW-1:0] integer_part_o,
  output logic [rdp_pkg::CntW-1:0] prefix_length_o,
  output logic [rdp_pkg::CntW-1:0] cycle_length_o,
  output logic                     status_o
);
  import rdp_pkg::*;

  rdp_cmd_t cmd;
  rdp_sts_t sts;

  rdp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rdp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .numerator_i    (numerator_i),
    .denominator_i  (denominator_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .integer_part_o (integer_part_o),
    .prefix_length_o(prefix_length_o),
    .cycle_length_o (cycle_length_o),
    .status_o       (status_o)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of repeating_decimal_period
// Drives numerator and denominator items through the valid/stall input,
// predicts the quotient, prefix length, cycle length and status of each one,
// and checks every result item in order against the prediction. The run goes
// through phases with and without idling on both sides and one long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [rdp_pkg::NumW-1:0] integer_part;
  logic [rdp_pkg::CntW-1:0] prefix_length;
  logic [rdp_pkg::CntW-1:0] cycle_length;
  logic                     status;
} period_result_t;

class period_board;
  period_result_t           expected_periods[$];
  bit                       remainder_seen[rdp_pkg::MaxDen];
  logic [rdp_pkg::CntW-1:0] first_digit_at[rdp_pkg::MaxDen];
  int unsigned              errors;

  function new();
    errors = 0;
    foreach (remainder_seen[i]) begin
      remainder_seen[i] = 1'b0;
      first_digit_at[i] = '0;
    end
  endfunction

  function void note_fraction(logic [rdp_pkg::NumW-1:0] num,
                              logic [rdp_pkg::DenW-1:0] den);
    period_result_t period;
    int unsigned    n;
    int unsigned    d;
    int unsigned    rem;
    int unsigned    digits;
    bit             done;
    period = '0;
    n = num;
    d = 32'(den);
    if (d == 0 || d > rdp_pkg::MaxDen) begin
      period.status = 1'b1;
    end else begin
      foreach (remainder_seen[i]) remainder_seen[i] = 1'b0;
      period.integer_part = n / d;
      rem = n % d;
      digits = 0;
      done = 1'b0;
      remainder_seen[rem[rdp_pkg::RemW-1:0]] = 1'b1;
      first_digit_at[rem[rdp_pkg::RemW-1:0]] = '0;
      for (int unsigned s = 0; s <= d + 1 && !done; s++) begin
        if (rem == 0) begin
          period.prefix_length = rdp_pkg::CntW'(digits);
          period.cycle_length = rdp_pkg::CntW'(1);
          done = 1'b1;
        end else begin
          rem = (rem * 10) % d;
          if (!remainder_seen[rem[rdp_pkg::RemW-1:0]]) begin
            digits++;
            remainder_seen[rem[rdp_pkg::RemW-1:0]] = 1'b1;
            first_digit_at[rem[rdp_pkg::RemW-1:0]] = rdp_pkg::CntW'(digits);
          end else begin
            period.prefix_length = first_digit_at[rem[rdp_pkg::RemW-1:0]];
            period.cycle_length =
              rdp_pkg::CntW'(digits - first_digit_at[rem[rdp_pkg::RemW-1:0]] + 1);
            done = 1'b1;
          end
        end
      end
    end
    expected_periods.push_back(period);
  endfunction

  function void check_period(logic [rdp_pkg::NumW-1:0] integer_part,
                             logic [rdp_pkg::CntW-1:0] prefix_length,
                             logic [rdp_pkg::CntW-1:0] cycle_length,
                             logic                     status);
    period_result_t want;
    if (expected_periods.size() == 0) begin
      $error("result item with no expected item: integer_part %0d", integer_part);
      errors++;
      return;
    end
    want = expected_periods.pop_front();
    if (integer_part !== want.integer_part) begin
      $error("integer_part: expected %0d, got %0d", want.integer_part, integer_part);
      errors++;
    end
    if (prefix_length !== want.prefix_length) begin
      $error("prefix_length: expected %0d, got %0d", want.prefix_length, prefix_length);
      errors++;
    end
    if (cycle_length !== want.cycle_length) begin
      $error("cycle_length: expected %0d, got %0d", want.cycle_length, cycle_length);
      errors++;
    end
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      errors++;
    end
  endfunction

  function int unsigned outstanding();
    return expected_periods.size();
  endfunction
endclass

module tb_top;
  localparam int QuietLimit = 100000;
  localparam int TailCycles = 64;
  localparam int HoldCycles = 400;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic [rdp_pkg::NumW-1:0] numerator_i   = '0;
  logic [rdp_pkg::DenW-1:0] denominator_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic [rdp_pkg::NumW-1:0] integer_part_o;
  logic [rdp_pkg::CntW-1:0] prefix_length_o;
  logic [rdp_pkg::CntW-1:0] cycle_length_o;
  logic                     status_o;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_count = 0;
  period_board board;

  repeating_decimal_period DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .numerator_i    (numerator_i),
    .denominator_i  (denominator_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .integer_part_o (integer_part_o),
    .prefix_length_o(prefix_length_o),
    .cycle_length_o (cycle_length_o),
    .status_o       (status_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_period(integer_part_o, prefix_length_o, cycle_length_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic offer_fraction(input logic [rdp_pkg::NumW-1:0] num,
                                input logic [rdp_pkg::DenW-1:0] den);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    numerator_i   <= num;
    denominator_i <= den;
    do @(posedge clk_i); while (in_stall_o);
    board.note_fraction(num, den);
  endtask

  task automatic offer_random_fractions(input int count);
    logic [rdp_pkg::NumW-1:0] num;
    logic [rdp_pkg::DenW-1:0] den;
    int unsigned              pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        den = $urandom_range(1) ? '0 : rdp_pkg::DenW'($urandom_range(8191, 4097));
      end else if (pick < 70) begin
        den = rdp_pkg::DenW'($urandom_range(64, 1));
      end else if (pick < 93) begin
        den = rdp_pkg::DenW'($urandom_range(512, 65));
      end else begin
        den = rdp_pkg::DenW'($urandom_range(4096, 513));
      end
      case ($urandom_range(3))
        0:       num = $urandom_range(1000);
        1:       num = den * $urandom_range(100000);
        default: num = $urandom;
      endcase
      offer_fraction(num, den);
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_fraction(32'd0, 13'd1);
    offer_fraction(32'hFFFF_FFFF, 13'd1);
    offer_fraction(32'd1, 13'd0);
    offer_fraction(32'hFFFF_FFFF, 13'h1FFF);
    offer_fraction(32'd5, 13'd4097);
    offer_fraction(32'd1, 13'd2);
    offer_fraction(32'd1, 13'd3);
    offer_fraction(32'd1, 13'd6);
    offer_fraction(32'd1, 13'd7);
    offer_fraction(32'd22, 13'd7);
    offer_fraction(32'd3, 13'd8);
    offer_fraction(32'd84, 13'd12);
    offer_fraction(32'd1, 13'd97);
    offer_fraction(32'hFFFF_FFFF, 13'd4096);
    offer_fraction(32'd1, 13'd4093);
    offer_fraction(32'hAAAA_5555, 13'd4095);
    offer_fraction(32'd0, 13'd4096);

    offer_random_fractions(20);
    idle_pct = 79;
    offer_random_fractions(20);
    idle_pct  = 0;
    stall_pct = 79;
    offer_random_fractions(20);
    idle_pct  = 31;
    stall_pct = 31;
    offer_random_fractions(20);
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = HoldCycles;
    offer_random_fractions(20);
    in_valid_i <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/rdp_pkg.sv
design/rdp_div.sv
design/rdp_datapath.sv
design/rdp_ctrl.sv
design/repeating_decimal_period.sv
sim/tb_top.sv
